// File: rtl/mpma_pkg.sv
// Shared types and constants for the median-prefiltered moving average core.
// Used by the front, queue, back, top level and checker; no dependencies.
`default_nettype none

package mpma_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH     = 2;

  // Width of window_size, fill_count and the config write data.
  localparam int FILL_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [FILL_W-1:0] WINDOW_RESET = 7'd8;
  localparam logic              MEDIAN_RESET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIAN = 1'b1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_PRIME  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } bk_state_t;

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    logic              clear;
    logic              median_en;
    logic [FILL_W-1:0] window_size;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/mpma_front.sv
// Front part: accepts input transfers, applies the median-of-three prefilter
// and pushes {func, value} into the queue. Depends on mpma_pkg.
`default_nettype none

module mpma_front #(
  parameter int SAMPLE_BITS = mpma_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpma_pkg::ctl_t       ctl,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                 in_tuser,   // func
  input  logic                 q_full,
  output logic                 q_push,
  output logic [SAMPLE_BITS:0] q_item      // {func, entered value}
);
  import mpma_pkg::*;

  logic signed [SAMPLE_BITS-1:0] h0_r, h1_r, h2_r;
  logic signed [SAMPLE_BITS-1:0] h0_nxt, h1_nxt, h2_nxt;
  logic [1:0]                    fill_r, fill_nxt;

  logic signed [SAMPLE_BITS-1:0] v, entered;
  logic signed [SAMPLE_BITS-1:0] med_a, med_b, lo, hi, hi_c, med;
  logic                          accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign v         = $signed(in_tdata[SAMPLE_BITS-1:0]);

  // Once the history is full the oldest entry shifts out first.
  assign med_a = (fill_r == 2'd3) ? h1_r : h0_r;
  assign med_b = (fill_r == 2'd3) ? h2_r : h1_r;
  assign lo    = (med_a < med_b) ? med_a : med_b;
  assign hi    = (med_a < med_b) ? med_b : med_a;
  assign hi_c  = (hi < v) ? hi : v;
  assign med   = (lo > hi_c) ? lo : hi_c;

  always_comb begin
    h0_nxt   = h0_r;
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    fill_nxt = fill_r;
    entered  = v;
    if (ctl.clear) begin
      fill_nxt = 2'd0;
    end else if (accept) begin
      if (in_tuser == FUNC_PRIME) begin
        h0_nxt   = v;
        h1_nxt   = v;
        h2_nxt   = v;
        fill_nxt = 2'd3;
      end else if (ctl.median_en) begin
        case (fill_r)
          2'd0: begin
            h0_nxt   = v;
            fill_nxt = 2'd1;
          end
          2'd1: begin
            h1_nxt   = v;
            fill_nxt = 2'd2;
          end
          2'd2: begin
            h2_nxt   = v;
            fill_nxt = 2'd3;
            entered  = med;
          end
          default: begin
            h0_nxt  = h1_r;
            h1_nxt  = h2_r;
            h2_nxt  = v;
            entered = med;
          end
        endcase
      end
    end
  end

  assign q_push = accept;
  assign q_item = {in_tuser, entered};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r <= h0_nxt;
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/mpma_fifo.sv
// Short queue between the front and back parts.
// Register-based, first-word fall-through. Depends on mpma_pkg for its default depth.
`default_nettype none

module mpma_fifo #(
  parameter int W     = mpma_pkg::SAMPLE_BITS_DEF + 1,
  parameter int DEPTH = mpma_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mpma_back.sv
// Back part: ring memory, running sum, bit-serial divider and output register.
// Pops {func, value} items from the queue. Depends on mpma_pkg.
`default_nettype none

module mpma_back #(
  parameter int WINDOW_MAX  = mpma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mpma_pkg::SAMPLE_BITS_DEF,
  localparam int OUT_W = ((2 * SAMPLE_BITS + mpma_pkg::FILL_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpma_pkg::ctl_t       ctl,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [SAMPLE_BITS:0] q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata
);
  import mpma_pkg::*;

  localparam int WIN_EFF = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W   = SAMPLE_BITS + ((WIN_EFF > 1) ? $clog2(WIN_EFF) : 0);
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int WCMP_W  = (SLOT_W + 1 > FILL_W) ? SLOT_W + 1 : FILL_W;

  bk_state_t state_r, state_nxt;

  logic                          func_r;
  logic signed [SAMPLE_BITS-1:0] val_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [FILL_W-1:0]             held_r, held_nxt;
  logic [SUM_W-1:0]              dvd_r, dvd_nxt;
  logic [FILL_W-1:0]             rem_r, rem_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]              out_data_r, out_data_nxt;

  logic [SAMPLE_BITS-1:0]        ring [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]        rd_data_r;
  logic                          wr_en;
  logic [SLOT_W-1:0]             wr_addr;
  logic [SAMPLE_BITS-1:0]        wr_data;

  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SUM_W:0]         upd_sum;
  logic signed [SUM_W-1:0]       sum_new;
  logic [SLOT_W:0]               slot_inc;
  logic                          slot_wrap;
  logic [FILL_W:0]               shifted;
  logic                          ge;
  logic [SUM_W-1:0]              avg_full;

  // Slots at or past the fill count were never written since the last clear
  // and hold zero as far as the sum is concerned.
  assign old_val = (held_r == ctl.window_size) ? $signed(rd_data_r) : '0;
  assign upd_sum = (SUM_W+1)'(sum_r) - (SUM_W+1)'(old_val) + (SUM_W+1)'(val_r);
  assign sum_new = SUM_W'(upd_sum);

  assign slot_inc  = {1'b0, slot_r} + 1'b1;
  assign slot_wrap = (WCMP_W'(slot_inc) == WCMP_W'(ctl.window_size));

  // Restoring divide of |sum| by the fill count, one quotient bit per cycle.
  assign shifted  = {rem_r, dvd_r[SUM_W-1]};
  assign ge       = (shifted >= {1'b0, held_r});
  assign avg_full = neg_r ? (~dvd_r + 1'b1) : dvd_r;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    held_nxt      = held_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_data       = val_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        wr_en = 1'b1;
        if (func_r == FUNC_PRIME) begin
          wr_addr   = '0;
          sum_nxt   = SUM_W'(val_r);
          held_nxt  = FILL_W'(1);
          slot_nxt  = (ctl.window_size == FILL_W'(1)) ? '0 : SLOT_W'(1);
          state_nxt = ST_IDLE;
        end else begin
          sum_nxt   = sum_new;
          slot_nxt  = slot_wrap ? '0 : SLOT_W'(slot_inc);
          held_nxt  = (held_r < ctl.window_size) ? held_r + 1'b1 : held_r;
          neg_nxt   = sum_new[SUM_W-1];
          dvd_nxt   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? FILL_W'(shifted - {1'b0, held_r}) : FILL_W'(shifted);
        dvd_nxt  = {dvd_r[SUM_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({held_r, val_r, avg_full[SAMPLE_BITS-1:0]});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ctl.clear) begin
      sum_nxt  = '0;
      slot_nxt = '0;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      slot_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      func_r <= q_item[SAMPLE_BITS];
      val_r  <= $signed(q_item[SAMPLE_BITS-1:0]);
    end
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rd_data_r <= ring[slot_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/median_prefiltered_moving_average_core.sv
// Results come from the bit-serial divider in the back part (SUM_W = 30 at the
// defaults). The back part pops a new item only when idle, once the previous
// result is in the output register; a priming item skips the divider and gives no result.
// Reset (rst_n low, synchronous): window_size 8, median on, window empty; the
// ring memory is not swept, the fill count marks which slots count as zero.
// Depends on mpma_pkg, mpma_front, mpma_fifo, mpma_back.
`default_nettype none

module median_prefiltered_moving_average_core #(
  parameter int WINDOW_MAX  = mpma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mpma_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + mpma_pkg::FILL_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,  // sample
  input  logic                           in_tuser,  // func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata, // average, filtered_sample, fill_count
  input  logic                           cfg_we,
  input  logic [mpma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpma_pkg::FILL_W-1:0]    cfg_wdata
);
  import mpma_pkg::*;

  logic [FILL_W-1:0]    window_r, window_nxt;
  logic                 median_r, median_nxt;
  logic [FILL_W-1:0]    cfg_win;
  logic                 win_write;
  ctl_t                 ctl;

  logic                 q_push, q_pop, q_full, q_empty;
  logic [SAMPLE_BITS:0] q_in, q_out;

  // A zero window write is dropped; oversize values saturate.
  assign win_write = cfg_we && (cfg_index == REG_WINDOW) && (cfg_wdata != '0);
  assign cfg_win   = (int'(cfg_wdata) > WINDOW_MAX) ? FILL_W'(WINDOW_MAX) : cfg_wdata;

  always_comb begin
    window_nxt = window_r;
    median_nxt = median_r;
    if (win_write) begin
      window_nxt = cfg_win;
    end
    if (cfg_we && (cfg_index == REG_MEDIAN)) begin
      median_nxt = cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      median_r <= MEDIAN_RESET;
    end else begin
      window_r <= window_nxt;
      median_r <= median_nxt;
    end
  end

  assign ctl.clear       = win_write;
  assign ctl.median_en   = median_r;
  assign ctl.window_size = window_r;

  mpma_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  mpma_fifo #(
    .W    (SAMPLE_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  mpma_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_out),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/mpma_checker.sv
// Port-level checks for median_prefiltered_moving_average_core, bound to the top.
// Depends on mpma_pkg.
`default_nettype none

module mpma_checker #(
  parameter int WINDOW_MAX  = mpma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mpma_pkg::SAMPLE_BITS_DEF,
  localparam int OUT_W = ((2 * SAMPLE_BITS + mpma_pkg::FILL_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  import mpma_pkg::*;

  logic [FILL_W-1:0] fill;

  assign fill = out_tdata[2*SAMPLE_BITS +: FILL_W];

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill != '0)
    else $error("result with empty window");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(fill) <= WINDOW_MAX)
    else $error("fill count above window maximum");

endmodule

bind median_prefiltered_moving_average_core mpma_checker #(
  .WINDOW_MAX (WINDOW_MAX),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mpma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
